### rtl/core/dchf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dchf_pkg
// Types and codes shared by the detection confirm and hold filter.
// ----------------------------------------------------------------------------
package dchf_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAMES_TO_CONFIRM = 2'd0;
  localparam logic [1:0] CFG_MISSES_ALLOWED    = 2'd1;
  localparam logic [1:0] CFG_CONFIDENCE_FLOOR  = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  FRAMES_TO_CONFIRM_RST = 8'd3;
  localparam logic [7:0]  MISSES_ALLOWED_RST    = 8'd2;
  localparam logic [15:0] CONFIDENCE_FLOOR_RST  = 16'd32768;

  // Frame modes
  localparam logic [1:0] MODE_RUN      = 2'd0;
  localparam logic [1:0] MODE_DISABLED = 2'd1;

  // Tracking stages
  localparam logic [1:0] STAGE_NONE = 2'd0;
  localparam logic [1:0] STAGE_CAND = 2'd1;
  localparam logic [1:0] STAGE_CONF = 2'd2;

  // Result status codes
  localparam logic [2:0] STATUS_IDLE     = 3'd0;
  localparam logic [2:0] STATUS_CAND     = 3'd1;
  localparam logic [2:0] STATUS_CONF     = 3'd2;
  localparam logic [2:0] STATUS_DISABLED = 3'd3;
  localparam logic [2:0] STATUS_ERROR    = 3'd4;

  localparam logic [15:0] RUN_MAX  = 16'hFFFF;
  localparam logic [7:0]  MISS_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  frame_mode;
    logic        has_detection;
    logic [7:0]  sign_code;
    logic [15:0] label_code;
    logic [15:0] confidence;
    logic [31:0] frame_time;
    logic        frame_end;
  } in_t;

  typedef struct packed {
    logic [2:0]  track_status;
    logic [7:0]  tracked_sign;
    logic [15:0] tracked_label;
    logic [15:0] run_length;
    logic [7:0]  run_needed;
    logic [31:0] confirm_time;
    logic [31:0] seen_time;
  } out_t;

  typedef struct packed {
    logic [7:0]  frames_to_confirm;
    logic [7:0]  misses_allowed;
    logic [15:0] confidence_floor;
  } cfg_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  sign;
    logic [15:0] label;
  } pick_t;

endpackage
`default_nettype wire

### rtl/core/dchf_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dchf_cfg
// Configuration register file of the filter.
// ----------------------------------------------------------------------------
module dchf_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  output dchf_pkg::cfg_t     cfg_o
);
  import dchf_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frames_to_confirm <= FRAMES_TO_CONFIRM_RST;
      cfg_q.misses_allowed    <= MISSES_ALLOWED_RST;
      cfg_q.confidence_floor  <= CONFIDENCE_FLOOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAMES_TO_CONFIRM: cfg_q.frames_to_confirm <= cfg_data_i[7:0];
        CFG_MISSES_ALLOWED:    cfg_q.misses_allowed    <= cfg_data_i[7:0];
        CFG_CONFIDENCE_FLOOR:  cfg_q.confidence_floor  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/dchf_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dchf_pick
// Per-frame pick of the first usable detection.
// ----------------------------------------------------------------------------
module dchf_pick (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire dchf_pkg::in_t item_i,
  input  wire logic [15:0]   floor_i,
  output dchf_pkg::pick_t    pick_o
);
  import dchf_pkg::*;

  pick_t pick_q;
  logic  usable;

  assign usable = item_i.has_detection && (item_i.sign_code != 8'd0) &&
                  (item_i.confidence >= floor_i);

  // Earliest pick wins; the current item counts when nothing is held yet.
  always_comb begin
    pick_o = pick_q;
    if (!pick_q.found && usable) begin
      pick_o.found = 1'b1;
      pick_o.sign  = item_i.sign_code;
      pick_o.label = item_i.label_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q <= '0;
    end else if (adv_i) begin
      if (item_i.frame_end) begin
        pick_q <= '0;
      end else begin
        pick_q <= pick_o;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/dchf_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dchf_track
// Tracked sign state and frame-end result formation.
// ----------------------------------------------------------------------------
module dchf_track (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            end_i,
  input  wire logic [1:0]      mode_i,
  input  wire logic [31:0]     now_i,
  input  wire dchf_pkg::pick_t pick_i,
  input  wire dchf_pkg::cfg_t  cfg_i,
  output dchf_pkg::out_t       res_o
);
  import dchf_pkg::*;

  logic [1:0]  stage_q, stage_d;
  logic [7:0]  sign_q, sign_d;
  logic [15:0] label_q, label_d;
  logic [15:0] run_q, run_d;
  logic [31:0] ctime_q, ctime_d;
  logic [31:0] stime_q, stime_d;
  logic [7:0]  miss_q, miss_d;

  logic [2:0]  status;
  logic [15:0] run_inc;
  logic [15:0] ftc_ext;
  logic [7:0]  miss_inc;
  logic        tracked;

  assign ftc_ext  = {8'd0, cfg_i.frames_to_confirm};
  assign run_inc  = (run_q == RUN_MAX) ? RUN_MAX : run_q + 16'd1;
  assign miss_inc = (miss_q == MISS_MAX) ? MISS_MAX : miss_q + 8'd1;

  always_comb begin
    stage_d = stage_q;
    sign_d  = sign_q;
    label_d = label_q;
    run_d   = run_q;
    ctime_d = ctime_q;
    stime_d = stime_q;
    miss_d  = miss_q;
    status  = STATUS_IDLE;

    if (mode_i != MODE_RUN) begin
      // Disabled or error: drop all tracking.
      stage_d = STAGE_NONE;
      sign_d  = '0;
      label_d = '0;
      run_d   = '0;
      ctime_d = '0;
      stime_d = '0;
      miss_d  = '0;
      status  = (mode_i == MODE_DISABLED) ? STATUS_DISABLED : STATUS_ERROR;
    end else if (!pick_i.found) begin
      if (stage_q != STAGE_NONE && miss_inc <= cfg_i.misses_allowed) begin
        miss_d = miss_inc;
        status = {1'b0, stage_q};
      end else begin
        stage_d = STAGE_NONE;
        sign_d  = '0;
        label_d = '0;
        run_d   = '0;
        ctime_d = '0;
        stime_d = '0;
        miss_d  = '0;
      end
    end else if (stage_q != STAGE_NONE && sign_q == pick_i.sign &&
                 label_q == pick_i.label) begin
      miss_d  = '0;
      stime_d = now_i;
      if (stage_q == STAGE_CONF) begin
        run_d = (run_inc > ftc_ext) ? run_inc : ftc_ext;
        if (ctime_q == 32'd0) begin
          ctime_d = now_i;
        end
      end else if (run_inc >= ftc_ext) begin
        run_d   = run_inc;
        stage_d = STAGE_CONF;
        ctime_d = now_i;
      end else begin
        run_d   = run_inc;
        ctime_d = '0;
      end
      status = {1'b0, stage_d};
    end else begin
      // New sign: start over.
      miss_d  = '0;
      sign_d  = pick_i.sign;
      label_d = pick_i.label;
      stime_d = now_i;
      if (cfg_i.frames_to_confirm <= 8'd1) begin
        stage_d = STAGE_CONF;
        run_d   = ftc_ext;
        ctime_d = now_i;
      end else begin
        stage_d = STAGE_CAND;
        run_d   = 16'd1;
        ctime_d = '0;
      end
      status = {1'b0, stage_d};
    end
  end

  assign tracked = (status == STATUS_CAND) || (status == STATUS_CONF);

  always_comb begin
    res_o.track_status  = status;
    res_o.tracked_sign  = tracked ? sign_d  : '0;
    res_o.tracked_label = tracked ? label_d : '0;
    res_o.run_length    = tracked ? run_d   : '0;
    res_o.run_needed    = tracked ? cfg_i.frames_to_confirm : '0;
    res_o.confirm_time  = (status == STATUS_CONF) ? ctime_d : '0;
    res_o.seen_time     = tracked ? stime_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= STAGE_NONE;
      sign_q  <= '0;
      label_q <= '0;
      run_q   <= '0;
      ctime_q <= '0;
      stime_q <= '0;
      miss_q  <= '0;
    end else if (end_i) begin
      stage_q <= stage_d;
      sign_q  <= sign_d;
      label_q <= label_d;
      run_q   <= run_d;
      ctime_q <= ctime_d;
      stime_q <= stime_d;
      miss_q  <= miss_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/detection_confirm_hold_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// detection_confirm_hold_filter
// Frame-based sign tracker with confirmation and miss hold-off.
// ----------------------------------------------------------------------------
// The filter takes one detection transaction per cycle. Each transaction is
// captured in an input register; the next cycle the pick logic and the track
// update run as one short combinational pass, and a frame-end transaction
// loads its result into the output register as it leaves the input register,
// where the result is then offered to the consumer until taken. Throughput
// is one transaction per cycle; the only throttle is the output register: a
// frame-end transaction waits in the input register, and stalls the input
// behind it, while an earlier result is still held by a stalled consumer.
// Non-end transactions never wait on the output register.
// Only frame-end transactions produce a result. Write the configuration
// registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
module detection_confirm_hold_filter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // detection input
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dchf_pkg::in_t in_data_i,
  // result output
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output dchf_pkg::out_t     out_data_o,
  // configuration writes
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i
);
  import dchf_pkg::*;

  in_t   in_q;
  logic  in_vld_q;
  out_t  out_q;
  logic  out_vld_q;

  cfg_t  cfg;
  pick_t pick;
  out_t  res;
  logic  adv;
  logic  end_adv;

  // Advance the held transaction unless it needs the output register and
  // that register is still occupied.
  assign adv     = in_vld_q && (!in_q.frame_end || !out_vld_q || out_ready_i);
  assign end_adv = adv && in_q.frame_end;

  assign in_ready_o  = !in_vld_q || adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  dchf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dchf_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (in_q),
    .floor_i (cfg.confidence_floor),
    .pick_o  (pick)
  );

  dchf_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .end_i  (end_adv),
    .mode_i (in_q.frame_mode),
    .now_i  (in_q.frame_time),
    .pick_i (pick),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register: capture a new transaction whenever the slot frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Output register: load on frame end, drop once the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (end_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_adv) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire

### sim/tb_detection_confirm_hold_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_confirm_hold_filter
// Self-checking bench for the sign confirm and hold filter. A class keeps its
// own copy of the tracking state, predicts one report per frame-end
// transaction and compares each report the filter delivers with the oldest
// prediction. Directed frames walk through the corner cases, a long run of
// matching frames carries the run length through confirmation at the top
// threshold, and random phases with bursty input, a stalling consumer and
// changing settings cover the rest.
// ----------------------------------------------------------------------------
module tb_detection_confirm_hold_filter;
  import dchf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          SHOWN_ERRORS = 10;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PHASE_ITEMS  = 160;
  localparam int          SAT_FRAMES   = 300;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_style_e;

  // --------------------------------------------------------------------------
  // Tracking model and report store
  // --------------------------------------------------------------------------
  class track_model;
    cfg_t        cfg;
    pick_t       pick;
    logic [1:0]  stage;
    logic [7:0]  sign;
    logic [15:0] label;
    logic [15:0] run;
    logic [31:0] confirm_at;
    logic [31:0] seen_at;
    logic [7:0]  misses;
    out_t        pending_reports[$];
    int          failures;

    function new();
      cfg = '{FRAMES_TO_CONFIRM_RST, MISSES_ALLOWED_RST, CONFIDENCE_FLOOR_RST};
      pick = '0;
      failures = 0;
      drop_track();
    endfunction

    function void drop_track();
      stage = STAGE_NONE;
      sign = '0;
      label = '0;
      run = '0;
      confirm_at = '0;
      seen_at = '0;
      misses = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_FRAMES_TO_CONFIRM: cfg.frames_to_confirm = val[7:0];
        CFG_MISSES_ALLOWED:    cfg.misses_allowed = val[7:0];
        CFG_CONFIDENCE_FLOOR:  cfg.confidence_floor = val;
        default: ;
      endcase
    endfunction

    function logic [2:0] status_of(logic [1:0] stg);
      return (stg == STAGE_CONF) ? STATUS_CONF : STATUS_CAND;
    endfunction

    // Build the report for the given status; untracked fields stay zero.
    function void push_report(logic [2:0] status);
      out_t r;
      bit   tracked;
      r = '0;
      tracked = (status == STATUS_CAND) || (status == STATUS_CONF);
      r.track_status = status;
      if (tracked) begin
        r.tracked_sign  = sign;
        r.tracked_label = label;
        r.run_length    = run;
        r.run_needed    = cfg.frames_to_confirm;
        r.seen_time     = seen_at;
      end
      if (status == STATUS_CONF) r.confirm_time = confirm_at;
      pending_reports.push_back(r);
    endfunction

    // Advance the model by one accepted detection transaction.
    function void note_detection(in_t d);
      pick_t       got;
      logic [15:0] next_run;
      // Keep only the first usable detection of the frame, whatever its mode.
      if (d.has_detection && !pick.found && d.sign_code != 8'd0 &&
          d.confidence >= cfg.confidence_floor) begin
        pick = '{found: 1'b1, sign: d.sign_code, label: d.label_code};
      end
      if (!d.frame_end) return;
      got = pick;
      pick = '0;

      if (d.frame_mode != MODE_RUN) begin
        // Disabled, error and the unnamed fourth mode all clear tracking.
        drop_track();
        push_report(d.frame_mode == MODE_DISABLED ? STATUS_DISABLED : STATUS_ERROR);
      end else if (!got.found) begin
        if (misses != MISS_MAX) misses++;
        if (stage != STAGE_NONE && misses <= cfg.misses_allowed) begin
          push_report(status_of(stage));
        end else begin
          drop_track();
          push_report(STATUS_IDLE);
        end
      end else if (stage != STAGE_NONE && sign == got.sign && label == got.label) begin
        misses = '0;
        next_run = (run == RUN_MAX) ? RUN_MAX : run + 16'd1;
        if (stage == STAGE_CONF) begin
          run = (next_run > 16'(cfg.frames_to_confirm)) ? next_run
                                                       : 16'(cfg.frames_to_confirm);
          if (confirm_at == '0) confirm_at = d.frame_time;
        end else if (next_run >= 16'(cfg.frames_to_confirm)) begin
          run = next_run;
          stage = STAGE_CONF;
          confirm_at = d.frame_time;
        end else begin
          run = next_run;
          confirm_at = '0;
        end
        seen_at = d.frame_time;
        push_report(status_of(stage));
      end else begin
        // New identity: restart tracking, confirm at once for tiny thresholds.
        drop_track();
        sign = got.sign;
        label = got.label;
        seen_at = d.frame_time;
        if (cfg.frames_to_confirm <= 8'd1) begin
          stage = STAGE_CONF;
          run = 16'(cfg.frames_to_confirm);
          confirm_at = d.frame_time;
        end else begin
          stage = STAGE_CAND;
          run = 16'd1;
          confirm_at = '0;
        end
        push_report(status_of(stage));
      end
    endfunction

    function string show(out_t r);
      return $sformatf("st=%0d sign=%0h label=%0h run=%0d need=%0d confirm=%0h seen=%0h",
                       r.track_status, r.tracked_sign, r.tracked_label, r.run_length,
                       r.run_needed, r.confirm_time, r.seen_time);
    endfunction

    // Compare one delivered report with the oldest prediction.
    function void check_report(out_t seen);
      out_t want;
      if (pending_reports.size() == 0) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("[%0t] report with nothing outstanding: %s", $realtime, show(seen));
        return;
      end
      want = pending_reports.pop_front();
      if (seen.track_status  !== want.track_status  ||
          seen.tracked_sign  !== want.tracked_sign  ||
          seen.tracked_label !== want.tracked_label ||
          seen.run_length    !== want.run_length    ||
          seen.run_needed    !== want.run_needed    ||
          seen.confirm_time  !== want.confirm_time  ||
          seen.seen_time     !== want.seen_time) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("[%0t] report mismatch\n  expected %s\n  actual   %s",
                   $realtime, show(want), show(seen));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block connections
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_t         in_data = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_FRAMES_TO_CONFIRM;
  logic [15:0] cfg_data = '0;

  // Receiver controls: one-shot long hold-offs and a fully open mode.
  int          hold_requests = 0;
  int          holds_done = 0;
  logic        rx_fast = 1'b0;
  rx_style_e   rx_style = RX_OPEN;
  int          rx_left = 0;

  int unsigned cycles = 0;
  track_model  model;

  always #2 clk = ~clk;

  detection_confirm_hold_filter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      // Check the delivered report first so a same-cycle input cannot mask it.
      if (out_valid && out_ready) model.check_report(out_data);
      if (in_valid && in_ready) model.note_detection(in_data);
      if (cfg_valid && cfg_ready) model.write_reg(cfg_index, cfg_data);
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: change ready at the falling edge following a pattern of its own
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_requests != holds_done) begin
      // Hold off long enough for the filter to fill and stall its input.
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
      holds_done++;
    end else if (rx_fast) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_style = rx_style_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_style)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        RX_PULSE:  out_ready <= ((rx_left % 8) < 3);
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // Offer one detection transaction and hold it until accepted.
  task automatic send_item(in_t d);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_det(logic [1:0] mode, logic has, logic [7:0] sgn, logic [15:0] lbl,
                          logic [15:0] conf, logic [31:0] t, logic last);
    in_t d;
    d.frame_mode = mode;
    d.has_detection = has;
    d.sign_code = sgn;
    d.label_code = lbl;
    d.confidence = conf;
    d.frame_time = t;
    d.frame_end = last;
    send_item(d);
  endtask

  // Drop valid and idle the input for a span set by n (n >= 1).
  task automatic pause_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending, wait for every outstanding report, then let the pipe settle.
  task automatic wait_idle();
    pause_input(1);
    while (model.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [7:0] ftc, logic [7:0] mis, logic [15:0] flr);
    write_reg(CFG_FRAMES_TO_CONFIRM, 16'(ftc));
    write_reg(CFG_MISSES_ALLOWED, 16'(mis));
    write_reg(CFG_CONFIDENCE_FLOOR, flr);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          p;
    int          i;
    int          k;
    int          n;
    int          sent;
    int          burst_left;
    bit          empty;
    bit          hold_pending;
    in_t         d;
    logic [31:0] now;
    logic [7:0]  scene_sign;
    logic [15:0] scene_label;
    logic [7:0]  ftc;
    logic [7:0]  mis;
    logic [15:0] flr;

    model = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames at reset settings: confirm 3, misses 2, floor one half.
    // Skip the unknown sign and take the first known one.
    send_det(MODE_RUN, 1'b1, 8'd0, 16'hAAAA, 16'hFFFF, 32'd10, 1'b0);
    send_det(MODE_RUN, 1'b1, 8'd5, 16'hFFFF, 16'hFFFF, 32'd10, 1'b1);
    // Just below the floor: a miss, candidate held.
    send_det(MODE_RUN, 1'b1, 8'd5, 16'hFFFF, 16'h7FFF, 32'd20, 1'b1);
    // Item without detection never picks, even with good fields.
    send_det(MODE_RUN, 1'b0, 8'd5, 16'hFFFF, 16'hFFFF, 32'd30, 1'b1);
    // Exactly on the floor picks; the second detection is ignored.
    send_det(MODE_RUN, 1'b1, 8'd5, 16'hFFFF, 16'h8000, 32'd40, 1'b0);
    send_det(MODE_RUN, 1'b1, 8'd9, 16'h0001, 16'hFFFF, 32'd40, 1'b1);
    // Pick made on a disabled item still counts; only the end item's mode matters.
    send_det(MODE_DISABLED, 1'b1, 8'd5, 16'hFFFF, 16'hFFFF, 32'd50, 1'b0);
    send_det(MODE_RUN, 1'b0, 8'd0, 16'h0000, 16'h0000, 32'd50, 1'b1);
    // Confirmed match at time zero keeps the earlier confirm time.
    send_det(MODE_RUN, 1'b1, 8'd5, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1);
    // Same sign, other label: a new candidate.
    send_det(MODE_RUN, 1'b1, 8'd5, 16'hFFFE, 16'h8000, 32'd60, 1'b1);
    // Four empty frames: held, held, dropped, then idle.
    for (i = 0; i < 4; i++) send_det(MODE_RUN, 1'b0, 8'd0, 16'd0, 16'd0, 32'(70 + 10 * i), 1'b1);
    send_det(2'd2, 1'b1, 8'hFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_det(2'd3, 1'b1, 8'hFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_det(MODE_DISABLED, 1'b1, 8'hFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_det(MODE_RUN, 1'b1, 8'hFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);

    // Confirm threshold zero: instant confirm with run zero, confirm time zero.
    wait_idle();
    set_config(8'd0, 8'd0, 16'd0);
    send_det(MODE_RUN, 1'b1, 8'd1, 16'h5555, 16'd0, 32'd0, 1'b1);
    send_det(MODE_RUN, 1'b1, 8'd1, 16'h5555, 16'd0, 32'd5, 1'b1);
    send_det(MODE_RUN, 1'b0, 8'd0, 16'd0, 16'd0, 32'd6, 1'b1);

    // Threshold one, a 254-frame miss window, top floor.
    wait_idle();
    set_config(8'd1, 8'd254, 16'hFFFF);
    send_det(MODE_RUN, 1'b1, 8'd2, 16'h0000, 16'hFFFE, 32'd90, 1'b1);
    send_det(MODE_RUN, 1'b1, 8'd2, 16'h0000, 16'hFFFF, 32'd100, 1'b1);
    // Hold through 254 empty frames, drop on the next one.
    for (i = 0; i < 255; i++) send_det(MODE_RUN, 1'b0, 8'd0, 16'd0, 16'd0, 32'(101 + i), 1'b1);

    // Long matching run: confirm at 255 and keep counting past it.
    wait_idle();
    rx_fast = 1'b1;
    set_config(8'hFF, 8'd2, 16'd0);
    for (i = 0; i < SAT_FRAMES; i++) begin
      d.frame_mode = MODE_RUN;
      d.has_detection = 1'b1;
      d.sign_code = 8'h7B;
      d.label_code = 16'h1234;
      d.confidence = 16'($urandom);
      d.frame_time = 32'(i + 1);
      d.frame_end = 1'b1;
      send_item(d);
    end
    wait_idle();
    rx_fast = 1'b0;

    // Random phases: well-formed frames around a persistent scene sign, with
    // noise in modes, identities and confidences.
    now = 32'd1000;
    scene_sign = 8'd1;
    scene_label = 16'd1;
    for (p = 0; p < 8; p++) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       ftc = 8'd0;
        1:       ftc = 8'd1;
        2:       ftc = 8'hFF;
        default: ftc = 8'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 5))
        0:       mis = 8'd0;
        1:       mis = 8'd254;
        default: mis = 8'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       flr = 16'd0;
        1:       flr = 16'hFFFF;
        2:       flr = CONFIDENCE_FLOOR_RST;
        default: flr = 16'($urandom);
      endcase
      set_config(ftc, mis, flr);

      hold_pending = (p == 1) || (p == 5);
      sent = 0;
      burst_left = $urandom_range(1, 24);
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0) begin
          scene_sign = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
          scene_label = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 3));
        end
        empty = ($urandom_range(0, 6) == 0);
        n = empty ? 1 : $urandom_range(1, 4);
        case ($urandom_range(0, 49))
          0:       now = '0;
          1:       now = $urandom;
          default: now = now + $urandom_range(1, 50);
        endcase
        for (k = 0; k < n; k++) begin
          d.frame_end = (k == n - 1);
          d.frame_mode = ($urandom_range(0, 15) == 0) ? 2'($urandom) : MODE_RUN;
          d.has_detection = !empty && ($urandom_range(0, 9) != 0);
          case ($urandom_range(0, 9))
            0:       d.sign_code = '0;
            1, 2:    d.sign_code = 8'($urandom);
            default: d.sign_code = scene_sign;
          endcase
          d.label_code = (d.sign_code == scene_sign && $urandom_range(0, 7) != 0)
                         ? scene_label : 16'($urandom);
          // Aim most confidences at or above the floor, some right at its edge.
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: d.confidence = 16'($urandom_range(32'(flr), 65535));
            5, 6, 7:       d.confidence = 16'($urandom);
            8:             d.confidence = flr - 16'(flr != 16'd0);
            default:       d.confidence = flr;
          endcase
          d.frame_time = (!d.frame_end && $urandom_range(0, 9) == 0) ? $urandom : now;
          send_item(d);
          if (d.has_detection || d.frame_end) sent++;
          // Start the long consumer stall while the sender keeps going.
          if (hold_pending) begin
            hold_requests++;
            hold_pending = 1'b0;
          end
          burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 10));
            burst_left = $urandom_range(1, 24);
          end
        end
      end
    end

    // Drain and report.
    wait_idle();
    if (model.failures == 0 && model.pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
